[hdl/nru_pkg.sv]
// Shared types and constants of the NRU page replacement block.
// No dependencies; every other file in this folder refers to it by scoped names.
`default_nettype none

package nru_pkg;

    // Fixed field widths of the request, result and configuration transactions.
    localparam int unsigned PAGE_IN_W  = 16;
    localparam int unsigned RND_W      = 16;
    localparam int unsigned FRAME_IDX_W = 6;
    localparam int unsigned FAULT_W    = 32;
    localparam int unsigned PERIOD_W   = 8;

    // Reset value of the reset_period register.
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 8'd4;

    // Remainder unit: bits of the random value retired per clock cycle.
    localparam int unsigned MOD_BITS_PER_CYC = 4;
    localparam int unsigned MOD_CYCLES       = RND_W / MOD_BITS_PER_CYC;

    // Broadcast control from the sequencer to every frame cell.
    typedef struct packed {
        logic load;       // selected cell takes the new page and becomes valid
        logic ref_set;    // selected cell sets its referenced bit
        logic ref_clear;  // every cell clears its referenced bit (wins over set)
    } t_cell_ctrl;

    // Status of one frame cell back to the sequencer.
    typedef struct packed {
        logic valid;      // cell holds a page
        logic referenced; // referenced bit
        logic match;      // valid and page equals the request
        logic cand;       // cell belongs to the lowest class present
        logic victim;     // candidate whose rank equals the chosen position
    } t_cell_stat;

endpackage

`default_nettype wire

[hdl/nru_req_if.sv]
// Request channel of the NRU page replacement block: valid, ready and payload.
// Depends on nru_pkg for the field widths.
`default_nettype none

interface nru_req_if;
    logic                          valid;
    logic                          ready;
    logic [nru_pkg::PAGE_IN_W-1:0] requested_page;
    logic [nru_pkg::RND_W-1:0]     random_value;

    modport source (output valid, output requested_page, output random_value, input ready);
    modport sink   (input valid, input requested_page, input random_value, output ready);
endinterface

`default_nettype wire

[hdl/nru_rsp_if.sv]
// Result channel of the NRU page replacement block: valid, ready and payload.
// Depends on nru_pkg for the field widths.
`default_nettype none

interface nru_rsp_if;
    logic                            valid;
    logic                            ready;
    logic                            hit;
    logic [nru_pkg::FRAME_IDX_W-1:0] frame_index;
    logic                            evicted_valid;
    logic [nru_pkg::PAGE_IN_W-1:0]   evicted_page;
    logic [nru_pkg::FAULT_W-1:0]     fault_count;

    modport source (output valid, output hit, output frame_index, output evicted_valid,
                    output evicted_page, output fault_count, input ready);
    modport sink   (input valid, input hit, input frame_index, input evicted_valid,
                    input evicted_page, input fault_count, output ready);
endinterface

`default_nettype wire

[hdl/nru_cfg_if.sv]
// Configuration write channel of the NRU page replacement block.
// Depends on nru_pkg for the register width.
`default_nettype none

interface nru_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [nru_pkg::PERIOD_W-1:0] reset_period;

    modport source (output valid, output reset_period, input ready);
    modport sink   (input valid, input reset_period, output ready);
endinterface

`default_nettype wire

[hdl/nru_cell.sv]
// One frame cell of the NRU table: valid bit, page number, referenced bit and rank stage.
// Depends on nru_pkg for the control and status structs.
`default_nettype none

module nru_cell #(
    parameter int unsigned PAGE_W = 16,
    parameter int unsigned CNT_W  = 4
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire nru_pkg::t_cell_ctrl i_ctrl,
    input  wire                      i_sel,
    input  wire        [PAGE_W-1:0]  i_page,
    input  wire                      i_want,
    input  wire        [CNT_W-1:0]   i_rank,
    input  wire        [CNT_W-1:0]   i_pick,
    output nru_pkg::t_cell_stat      o_stat,
    output logic       [PAGE_W-1:0]  o_page,
    output logic       [CNT_W-1:0]   o_rank
);

    logic              r_valid;
    logic              r_ref;
    logic [PAGE_W-1:0] r_page;
    logic [CNT_W-1:0]  r_rank;
    logic              w_cand;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_ref   <= 1'b0;
        end else begin
            if (i_sel && i_ctrl.load) begin
                r_valid <= 1'b1;
            end
            if (i_ctrl.ref_clear) begin
                r_ref <= 1'b0;
            end else if (i_sel && i_ctrl.ref_set) begin
                r_ref <= 1'b1;
            end
        end
    end

    // The page store and the rank stage need no reset: the page is read only
    // once valid, and the rank settles before it is used.
    always_ff @(posedge i_clk) begin
        if (i_sel && i_ctrl.load) begin
            r_page <= i_page;
        end
        r_rank <= i_rank;
    end

    assign w_cand = (r_ref == i_want);

    // Rank handed to the next cell: candidates up to and including this one.
    assign o_rank = r_rank + CNT_W'(w_cand);
    assign o_page = r_page;

    always_comb begin
        o_stat.valid      = r_valid;
        o_stat.referenced = r_ref;
        o_stat.match      = r_valid && (r_page == i_page);
        o_stat.cand       = w_cand;
        o_stat.victim     = w_cand && (r_rank == i_pick);
    end

endmodule

`default_nettype wire

[hdl/nru_mod.sv]
// Iterative remainder unit: random value modulo candidate count, a few bits per cycle.
// Depends on nru_pkg for the random value width and the bits retired per cycle.
`default_nettype none

module nru_mod #(
    parameter int unsigned CNT_W = 4
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_start,
    input  wire [nru_pkg::RND_W-1:0]  i_dividend,
    input  wire [CNT_W-1:0]           i_divisor,
    output logic                      o_done,
    output logic [CNT_W-1:0]          o_rem
);

    localparam int unsigned STEP_W = (nru_pkg::MOD_CYCLES > 1) ?
                                     $clog2(nru_pkg::MOD_CYCLES) : 1;

    logic                      r_busy;
    logic                      r_done;
    logic [STEP_W-1:0]         r_step;
    logic [nru_pkg::RND_W-1:0] r_shift;
    logic [CNT_W-1:0]          r_rem;
    logic [CNT_W-1:0]          r_div;
    logic [nru_pkg::RND_W-1:0] n_shift;
    logic [CNT_W-1:0]          n_rem;

    // Restoring remainder, most significant dividend bit first.
    always_comb begin
        logic [CNT_W:0] t;
        n_shift = r_shift;
        n_rem   = r_rem;
        for (int k = 0; k < nru_pkg::MOD_BITS_PER_CYC; k++) begin
            t       = {n_rem, n_shift[nru_pkg::RND_W-1]};
            n_shift = n_shift << 1;
            if (t >= {1'b0, r_div}) begin
                t = t - {1'b0, r_div};
            end
            n_rem = t[CNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_step <= '0;
        end else if (r_busy) begin
            r_step <= r_step + STEP_W'(1);
            if (r_step == STEP_W'(nru_pkg::MOD_CYCLES - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_shift <= i_dividend;
            r_rem   <= '0;
            r_div   <= i_divisor;
        end else if (r_busy) begin
            r_shift <= n_shift;
            r_rem   <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

[hdl/nru_page_replacement.sv]
// Top level of the not-recently-used page replacement block.
// Depends on nru_pkg, the three channel interfaces, nru_cell and nru_mod.
`default_nettype none

// The block keeps a table of FRAME_SLOTS frames as a row of cells, each with a
// valid bit, a page number of PAGE_BITS bits and a referenced bit. Every
// request transaction names a page and carries a random value. All cells
// compare the page at once. On a hit the frame's referenced bit is set; on a
// miss the saturating fault count rises and a victim is chosen among the
// lowest class present (unreferenced or empty frames, otherwise all frames):
// it is the candidate at position random_value mod (number of candidates),
// counted upwards from frame 0. The new page is loaded there with its
// referenced bit set, and the result reports the page that was pushed out.
// After every reset_period requests (zero meaning 256) all referenced bits are
// cleared once the request has been served. One request is worked on at a
// time. On a miss, candidate ranks travel down the row of cells one cell per
// cycle, and the remainder unit retires four bits of the random value per
// cycle. A finished result sits in an output register, so the next request
// is taken while the previous result still waits; a request finishes only
// once that register is free. The configuration channel is always ready and
// is meant to be written only while the block is idle.
module nru_page_replacement #(
    parameter int unsigned FRAME_SLOTS = 8,
    parameter int unsigned PAGE_BITS   = 16
) (
    input  wire    i_clk,
    input  wire    i_rst_n,
    nru_req_if.sink   i_req,
    nru_rsp_if.source o_rsp,
    nru_cfg_if.sink   i_cfg
);

    localparam int unsigned CNT_W  = $clog2(FRAME_SLOTS + 1);
    localparam int unsigned FIDX_W = (FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_MATCH  = 5'b00010,
        S_RANK   = 5'b00100,
        S_DIV    = 5'b01000,
        S_COMMIT = 5'b10000
    } t_state;

    t_state                         r_state;
    t_state                         n_state;
    logic [FIDX_W-1:0]              r_rank_cnt;
    logic [PAGE_BITS-1:0]           r_page;
    logic [nru_pkg::RND_W-1:0]      r_rnd;
    logic [nru_pkg::PERIOD_W-1:0]   r_period;
    logic [nru_pkg::PERIOD_W-1:0]   r_phase;
    logic [nru_pkg::FAULT_W-1:0]    r_faults;

    logic                           r_out_valid;
    logic                           r_out_hit;
    logic [nru_pkg::FRAME_IDX_W-1:0] r_out_frame;
    logic                           r_out_ev_valid;
    logic [nru_pkg::PAGE_IN_W-1:0]  r_out_ev_page;
    logic [nru_pkg::FAULT_W-1:0]    r_out_faults;

    nru_pkg::t_cell_stat            w_stat [FRAME_SLOTS];
    logic [PAGE_BITS-1:0]           w_cell_page [FRAME_SLOTS];
    logic [CNT_W-1:0]               w_rank_next [FRAME_SLOTS];
    logic [FRAME_SLOTS-1:0]         w_sel;
    logic [FRAME_SLOTS-1:0]         w_match_vec;
    logic [FRAME_SLOTS-1:0]         w_ref_vec;
    nru_pkg::t_cell_ctrl            w_ctrl;
    logic                           w_hit;
    logic                           w_want;
    logic [CNT_W-1:0]               w_count;
    logic [CNT_W-1:0]               w_pick;
    logic                           w_mod_start;
    logic                           w_mod_done;
    logic                           w_accept;
    logic                           w_out_free;
    logic                           w_commit;
    logic                           w_rank_end;
    logic [FIDX_W-1:0]              w_frame;
    logic                           w_ev_valid;
    logic [PAGE_BITS-1:0]           w_ev_page;
    logic [nru_pkg::PERIOD_W:0]     w_phase_inc;
    logic [nru_pkg::PERIOD_W:0]     w_period_len;
    logic                           w_clear_now;
    logic [nru_pkg::FAULT_W-1:0]    w_faults_next;

    // ------------------------------------------------------------------
    // Handshakes
    // ------------------------------------------------------------------
    assign i_req.ready = (r_state == S_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;
    assign i_cfg.ready = 1'b1;
    assign w_out_free  = !r_out_valid || o_rsp.ready;

    // ------------------------------------------------------------------
    // Row of frame cells. Each cell passes its running candidate count to
    // the next one through a register, so the rank of the last cell settles
    // once the counts have passed through the row with stable referenced bits.
    // ------------------------------------------------------------------
    for (genvar g = 0; g < FRAME_SLOTS; g++) begin : g_cell
        logic [CNT_W-1:0] w_rank_in;
        if (g == 0) begin : g_first
            assign w_rank_in = '0;
        end else begin : g_rest
            assign w_rank_in = w_rank_next[g-1];
        end

        nru_cell #(
            .PAGE_W (PAGE_BITS),
            .CNT_W  (CNT_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (w_ctrl),
            .i_sel   (w_sel[g]),
            .i_page  (r_page),
            .i_want  (w_want),
            .i_rank  (w_rank_in),
            .i_pick  (w_pick),
            .o_stat  (w_stat[g]),
            .o_page  (w_cell_page[g]),
            .o_rank  (w_rank_next[g])
        );

        assign w_match_vec[g] = w_stat[g].match;
        assign w_ref_vec[g]   = w_stat[g].referenced;
        // A hit touches the matching frame; a miss replaces the victim.
        assign w_sel[g]       = w_hit ? w_stat[g].match : w_stat[g].victim;
    end

    assign w_hit   = |w_match_vec;
    // Referenced frames are candidates only when every frame is referenced.
    assign w_want  = &w_ref_vec;
    assign w_count = w_rank_next[FRAME_SLOTS-1];

    // Pages are unique among valid frames and exactly one victim exists, so
    // the selected cell can be gathered with a plain OR.
    always_comb begin
        w_frame    = '0;
        w_ev_valid = 1'b0;
        w_ev_page  = '0;
        for (int i = 0; i < FRAME_SLOTS; i++) begin
            if (w_sel[i]) begin
                w_frame = w_frame | FIDX_W'(i);
            end
            if (w_stat[i].victim && w_stat[i].valid) begin
                w_ev_valid = 1'b1;
                w_ev_page  = w_ev_page | w_cell_page[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // Remainder unit: picks the victim's position among the candidates.
    // ------------------------------------------------------------------
    assign w_rank_end  = (r_state == S_RANK) && (r_rank_cnt == FIDX_W'(FRAME_SLOTS - 1));
    assign w_mod_start = w_rank_end;

    nru_mod #(
        .CNT_W (CNT_W)
    ) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_mod_start),
        .i_dividend (r_rnd),
        .i_divisor  (w_count),
        .o_done     (w_mod_done),
        .o_rem      (w_pick)
    );

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    assign w_commit = w_out_free &&
                      (((r_state == S_MATCH) && w_hit) || (r_state == S_COMMIT));

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_MATCH;
                end
            end
            S_MATCH: begin
                if (!w_hit) begin
                    n_state = S_RANK;
                end else if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_RANK: begin
                if (w_rank_end) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (w_mod_done) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Reference period: zero stands for 256. The clearing follows the request
    // it belongs to, so that request still sees the old referenced bits.
    assign w_phase_inc  = {1'b0, r_phase} + 9'd1;
    assign w_period_len = (r_period == '0) ? 9'd256 : {1'b0, r_period};
    assign w_clear_now  = (w_phase_inc >= w_period_len);

    assign w_faults_next = (!w_hit && (r_faults != '1)) ? r_faults + 32'd1 : r_faults;

    always_comb begin
        w_ctrl.load      = w_commit && !w_hit;
        w_ctrl.ref_set   = w_commit;
        w_ctrl.ref_clear = w_commit && w_clear_now;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rank_cnt  <= '0;
            r_period    <= nru_pkg::PERIOD_RESET;
            r_phase     <= '0;
            r_faults    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (r_state == S_RANK) begin
                r_rank_cnt <= r_rank_cnt + FIDX_W'(1);
            end else begin
                r_rank_cnt <= '0;
            end

            if (i_cfg.valid) begin
                r_period <= i_cfg.reset_period;
            end

            if (w_commit) begin
                r_faults    <= w_faults_next;
                r_phase     <= w_clear_now ? '0 : w_phase_inc[nru_pkg::PERIOD_W-1:0];
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Request payload and result payload registers.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_page <= PAGE_BITS'(32'(i_req.requested_page));
            r_rnd  <= i_req.random_value;
        end
        if (w_commit) begin
            r_out_hit      <= w_hit;
            r_out_frame    <= nru_pkg::FRAME_IDX_W'(w_frame);
            r_out_ev_valid <= !w_hit && w_ev_valid;
            r_out_ev_page  <= (!w_hit && w_ev_valid) ?
                              nru_pkg::PAGE_IN_W'(32'(w_ev_page)) : '0;
            r_out_faults   <= w_faults_next;
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.hit           = r_out_hit;
    assign o_rsp.frame_index   = r_out_frame;
    assign o_rsp.evicted_valid = r_out_ev_valid;
    assign o_rsp.evicted_page  = r_out_ev_page;
    assign o_rsp.fault_count   = r_out_faults;

`ifndef SYNTHESIS
    // Exactly one frame is touched or replaced by every finished request.
    a_one_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_commit |-> $onehot(w_sel))
        else $error("request finished without exactly one selected frame");

    // The candidate count handed to the remainder unit is never zero.
    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mod_start |-> (w_count != '0))
        else $error("zero candidates at victim selection");

    // The chosen position lies among the candidates once the remainder is ready.
    a_pick_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COMMIT) |-> (w_pick < w_count))
        else $error("victim position beyond the candidate count");

    // The fault count never falls and moves only when a request finishes.
    a_faults_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_commit |=> $stable(r_faults))
        else $error("fault count changed outside a finished request");

    // A clearing leaves every referenced bit low after the request.
    a_clear_all: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.ref_clear |=> (w_ref_vec == '0))
        else $error("referenced bits survived a clearing");
`endif

endmodule

`default_nettype wire
